// ===== rtl/ccs_pkg.sv =====
// Shared constants, types and the arctangent step table for the CORDIC cosine/sine unit.
package ccs_pkg;

  localparam int unsigned ITERATIONS  = 29;
  localparam int unsigned ITER_W      = $clog2(ITERATIONS + 2);
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned OUT_W       = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ATAN_DEPTH  = 10;
  localparam int unsigned ATAN_IDX_W  = $clog2(ATAN_DEPTH);
  localparam int unsigned ANGLE_SHIFT = 16;

  localparam logic [ANGLE_W-1:0] HALF_PI       = 16'd12868;
  localparam logic [ANGLE_W-1:0] PI            = 16'd25736;
  localparam logic [ANGLE_W-1:0] THREE_HALF_PI = 16'd38604;
  localparam logic [ANGLE_W-1:0] TWO_PI        = 16'd51472;

  localparam logic [DATA_W-1:0] START_SUM = 32'd421657428;
  localparam logic [DATA_W-1:0] START_VEC = 32'd652032874;

  typedef logic [ITER_W-1:0] iter_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } ccs_cmd_t;

  typedef struct packed {
    logic last;
  } ccs_status_t;

  function automatic logic [DATA_W-1:0] atan_step(input logic [ATAN_IDX_W-1:0] idx);
    logic [DATA_W-1:0] val;
    case (idx)
      4'd0:    val = 32'd248918915;
      4'd1:    val = 32'd131521918;
      4'd2:    val = 32'd66762579;
      4'd3:    val = 32'd33510843;
      4'd4:    val = 32'd16771758;
      4'd5:    val = 32'd8387925;
      4'd6:    val = 32'd4194219;
      4'd7:    val = 32'd2097141;
      4'd8:    val = 32'd1048575;
      4'd9:    val = 32'd524288;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/ccs_ctrl.sv =====
// Sequencer for the CORDIC unit: input handshake, iteration run and output word hand-off.
module ccs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ccs_pkg::ccs_status_t status_i,
  output ccs_pkg::ccs_cmd_t   cmd_o
);
  import ccs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (status_i.last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold the finished vector until the output register is free
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_RUN)
    else $error("accepted word did not start a run");

  a_last_to_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && status_i.last |=> state_q == ST_FINISH)
    else $error("run did not end after last rotation");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("emitted word not presented");

endmodule

// ===== rtl/ccs_datapath.sv =====
// Datapath: quadrant fold, shift-add rotation registers and the output word register.
module ccs_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic        [ccs_pkg::ANGLE_W-1:0]     angle_i,
  input  ccs_pkg::ccs_cmd_t                      cmd_i,
  output ccs_pkg::ccs_status_t                   status_o,
  output logic signed [ccs_pkg::OUT_W-1:0]       cosine_out_o,
  output logic signed [ccs_pkg::OUT_W-1:0]       sine_out_o
);
  import ccs_pkg::*;

  logic [ANGLE_W-1:0] wrap_w, fold_w;
  logic               neg_c_w, neg_s_w;

  logic        [DATA_W-1:0] target_q, target_d;
  logic        [DATA_W-1:0] sum_q, sum_d;
  logic        [DATA_W-1:0] rot_q, rot_d;
  logic signed [DATA_W-1:0] cx_q, cx_d;
  logic signed [DATA_W-1:0] sy_q, sy_d;
  logic signed [DATA_W-1:0] dx_w, dy_w;
  iter_t                    iter_q, iter_d;
  logic                     neg_c_q, neg_c_d;
  logic                     neg_s_q, neg_s_d;
  logic signed [OUT_W-1:0]  cos_q, cos_d;
  logic signed [OUT_W-1:0]  sin_q, sin_d;
  logic        [OUT_W-1:0]  cx_hi_w, sy_hi_w;

  // wrap one turn, then fold into the first quadrant
  always_comb begin
    wrap_w  = (angle_i > TWO_PI) ? angle_i - TWO_PI : angle_i;
    fold_w  = wrap_w;
    neg_c_w = 1'b0;
    neg_s_w = 1'b0;
    if (wrap_w > THREE_HALF_PI) begin
      fold_w  = TWO_PI - wrap_w;
      neg_s_w = 1'b1;
    end else if (wrap_w > PI) begin
      fold_w  = wrap_w - PI;
      neg_c_w = 1'b1;
      neg_s_w = 1'b1;
    end else if (wrap_w > HALF_PI) begin
      fold_w  = PI - wrap_w;
      neg_c_w = 1'b1;
    end
  end

  assign dx_w    = sy_q >>> iter_q;
  assign dy_w    = cx_q >>> iter_q;
  assign cx_hi_w = cx_q[DATA_W-1 -: OUT_W];
  assign sy_hi_w = sy_q[DATA_W-1 -: OUT_W];

  assign status_o.last = (iter_q == iter_t'(ITERATIONS));

  always_comb begin
    target_d = target_q;
    sum_d    = sum_q;
    rot_d    = rot_q;
    cx_d     = cx_q;
    sy_d     = sy_q;
    iter_d   = iter_q;
    neg_c_d  = neg_c_q;
    neg_s_d  = neg_s_q;
    cos_d    = cos_q;
    sin_d    = sin_q;
    if (cmd_i.load) begin
      target_d = DATA_W'(fold_w) << ANGLE_SHIFT;
      sum_d    = START_SUM;
      rot_d    = atan_step('0);
      cx_d     = START_VEC;
      sy_d     = START_VEC;
      iter_d   = iter_t'(1);
      neg_c_d  = neg_c_w;
      neg_s_d  = neg_s_w;
    end else if (cmd_i.step) begin
      if ($signed(target_q) > $signed(sum_q)) begin
        cx_d  = cx_q - dx_w;
        sy_d  = sy_q + dy_w;
        sum_d = sum_q + rot_q;
      end else begin
        cx_d  = cx_q + dx_w;
        sy_d  = sy_q - dy_w;
        sum_d = sum_q - rot_q;
      end
      // table runs out after ten entries; halve from then on
      if (iter_q < iter_t'(ATAN_DEPTH)) begin
        rot_d = atan_step(iter_q[ATAN_IDX_W-1:0]);
      end else begin
        rot_d = rot_q >> 1;
      end
      iter_d = iter_q + iter_t'(1);
    end
    if (cmd_i.emit) begin
      cos_d = neg_c_q ? OUT_W'(16'd0 - cx_hi_w) : cx_hi_w;
      sin_d = neg_s_q ? OUT_W'(16'd0 - sy_hi_w) : sy_hi_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      sum_q    <= '0;
      rot_q    <= '0;
      cx_q     <= '0;
      sy_q     <= '0;
      iter_q   <= '0;
      neg_c_q  <= 1'b0;
      neg_s_q  <= 1'b0;
      cos_q    <= '0;
      sin_q    <= '0;
    end else begin
      target_q <= target_d;
      sum_q    <= sum_d;
      rot_q    <= rot_d;
      cx_q     <= cx_d;
      sy_q     <= sy_d;
      iter_q   <= iter_d;
      neg_c_q  <= neg_c_d;
      neg_s_q  <= neg_s_d;
      cos_q    <= cos_d;
      sin_q    <= sin_d;
    end
  end

  assign cosine_out_o = cos_q;
  assign sine_out_o   = sin_q;

  a_load_first_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> iter_q == iter_t'(1))
    else $error("iteration count not restarted on load");

  a_emit_after_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> iter_q == iter_t'(ITERATIONS + 1))
    else $error("word emitted before all rotations done");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.emit |=> $stable(cos_q) && $stable(sin_q))
    else $error("output register changed without emit");

endmodule

// ===== rtl/cordic_cosine_sine_unit.sv =====
// Cosine/sine unit: top level joining the sequencer and the CORDIC datapath.
//
// Input channel: angle_i (unsigned, 2^-13 rad units, 0 to two pi) with
// in_valid_i / in_ready_o. A word is taken when both are high.
// Output channel: cosine_out_o / sine_out_o (signed Q1.14) with
// out_valid_o / out_ready_i.
// One word in flight at a time. After acceptance the datapath folds the
// angle, runs 29 shift-add rotations (one a cycle on one shared adder set)
// and then loads the output register once that register is free; in_ready_o
// rises again with the result, so a new word is taken only after the
// previous result is in the output register.
// A stalled receiver holds the result in the output register; a finished
// run waits until that register is free, and no new word is taken meanwhile.
// Reset (rst_ni low, asynchronous) empties the output and returns the
// sequencer to idle, ready for a word in the first cycle after release.
module cordic_cosine_sine_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic        [ccs_pkg::ANGLE_W-1:0] angle_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ccs_pkg::OUT_W-1:0]   cosine_out_o,
  output logic signed [ccs_pkg::OUT_W-1:0]   sine_out_o
);
  import ccs_pkg::*;

  ccs_cmd_t    cmd;
  ccs_status_t status;

  ccs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ccs_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .angle_i      (angle_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .cosine_out_o (cosine_out_o),
    .sine_out_o   (sine_out_o)
  );

endmodule

// ===== tb/tb_cordic_cosine_sine_unit.sv =====
// Self-checking testbench for the CORDIC cosine/sine unit with a bit-exact rotation predictor.
`timescale 1ns / 1ps

module tb_cordic_cosine_sine_unit;
  import ccs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned ARCTAN_LEN  = 10;
  localparam logic [DATA_W-1:0] ARCTAN_STEP [0:ARCTAN_LEN-1] = '{
    32'd248918915, 32'd131521918, 32'd66762579, 32'd33510843, 32'd16771758,
    32'd8387925,   32'd4194219,   32'd2097141,  32'd1048575,  32'd524288
  };

  typedef struct {
    logic        [ANGLE_W-1:0] angle;
    logic signed [OUT_W-1:0]   cosine;
    logic signed [OUT_W-1:0]   sine;
  } trig_word_t;

  logic                      clk_i;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic        [ANGLE_W-1:0] angle_i     = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [OUT_W-1:0]   cosine_out_o;
  logic signed [OUT_W-1:0]   sine_out_o;

  trig_word_t  pending_trig[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_stall_pct = 0;

  cordic_cosine_sine_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .angle_i     (angle_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cosine_out_o(cosine_out_o),
    .sine_out_o  (sine_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Fold to the first quadrant, rotate, then restore the signs.
  function automatic trig_word_t predict_trig(input logic [ANGLE_W-1:0] ang);
    logic        [ANGLE_W-1:0] folded;
    logic                      flip_cos;
    logic                      flip_sin;
    logic signed [DATA_W-1:0]  target;
    logic signed [DATA_W-1:0]  acc;
    logic signed [DATA_W-1:0]  xv;
    logic signed [DATA_W-1:0]  yv;
    logic signed [DATA_W-1:0]  xs;
    logic signed [DATA_W-1:0]  ys;
    logic        [DATA_W-1:0]  rot;
    trig_word_t                res;
    folded   = ang;
    flip_cos = 1'b0;
    flip_sin = 1'b0;
    if (folded > TWO_PI) folded = folded - TWO_PI;
    if (folded > THREE_HALF_PI) begin
      folded   = TWO_PI - folded;
      flip_sin = 1'b1;
    end else if (folded > PI) begin
      folded   = folded - PI;
      flip_cos = 1'b1;
      flip_sin = 1'b1;
    end else if (folded > HALF_PI) begin
      folded   = PI - folded;
      flip_cos = 1'b1;
    end
    target = {folded, 16'h0000};
    acc    = START_SUM;
    xv     = START_VEC;
    yv     = START_VEC;
    rot    = ARCTAN_STEP[0];
    for (int i = 1; i <= int'(ITERATIONS) && i < 32; i++) begin
      xs = yv >>> i;
      ys = xv >>> i;
      if (target > acc) begin
        xv  = xv - xs;
        yv  = yv + ys;
        acc = acc + rot;
      end else begin
        xv  = xv + xs;
        yv  = yv - ys;
        acc = acc - rot;
      end
      // table runs out after ten steps; halve from there on
      if (i < int'(ARCTAN_LEN)) rot = ARCTAN_STEP[i];
      else rot = rot >> 1;
    end
    res.angle  = ang;
    res.cosine = flip_cos ? 16'(16'h0000 - xv[31:16]) : xv[31:16];
    res.sine   = flip_sin ? 16'(16'h0000 - yv[31:16]) : yv[31:16];
    return res;
  endfunction

  // Uniform over the turn, with a share landing close to a quadrant boundary.
  function automatic logic [ANGLE_W-1:0] random_angle();
    int signed base;
    int signed val;
    if ($urandom_range(99) >= 25) return ANGLE_W'($urandom_range(0, TWO_PI));
    case ($urandom_range(4))
      0:       base = 0;
      1:       base = HALF_PI;
      2:       base = PI;
      3:       base = THREE_HALF_PI;
      default: base = TWO_PI;
    endcase
    val = base + $signed($urandom_range(0, 16)) - 8;
    if (val < 0) val = 0;
    if (val > int'(TWO_PI)) val = TWO_PI;
    return ANGLE_W'(val);
  endfunction

  // Valid stays up across back-to-back words; it only drops while idling.
  task automatic send_angle(input logic [ANGLE_W-1:0] ang);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    angle_i    <= ang;
    do @(posedge clk_i); while (!in_ready_o);
    pending_trig.push_back(predict_trig(ang));
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_trig.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned idle_pct,
                            input int unsigned stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_angle(random_angle());
  endtask

  task automatic test_quadrant_edges();
    logic [ANGLE_W-1:0] edge_angles[$];
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    edge_angles = '{16'd0, 16'd1, HALF_PI - 16'd1, HALF_PI, HALF_PI + 16'd1,
                    PI - 16'd1, PI, PI + 16'd1, THREE_HALF_PI - 16'd1,
                    THREE_HALF_PI, THREE_HALF_PI + 16'd1, TWO_PI - 16'd1, TWO_PI,
                    16'd6434, 16'd19302, 16'd32170, 16'd45038, 16'h7FFF, 16'h8000,
                    16'h5555, 16'hAAAA, 16'h3FFF, 16'hC000};
    foreach (edge_angles[k]) send_angle(edge_angles[k]);
    hold_until_drained();
  endtask

  task automatic test_streaming();
    run_random(500, 0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random(250, 59, 0);
    hold_until_drained();
    run_random(240, 59, 0);
  endtask

  task automatic test_receiver_stalls();
    run_random(480, 0, 59);
  endtask

  task automatic test_both_idle();
    run_random(480, 15, 15);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    trig_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_trig.size() == 0) begin
        $error("unexpected result word: cosine_out %0d sine_out %0d",
               cosine_out_o, sine_out_o);
        mismatch_count++;
      end else begin
        want = pending_trig.pop_front();
        if (cosine_out_o !== want.cosine) begin
          $error("cosine_out (angle %0d): expected %0d, got %0d",
                 want.angle, want.cosine, cosine_out_o);
          mismatch_count++;
        end
        if (sine_out_o !== want.sine) begin
          $error("sine_out (angle %0d): expected %0d, got %0d",
                 want.angle, want.sine, sine_out_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_quadrant_edges();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_trig.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
